// ===== rtl/cvl_pkg.sv =====
// Package for the compacting value list: sizes, operation and status codes,
// and the broadcast bundle that drives the row of storage cells.
// No dependencies.
`default_nettype none

package cvl_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int OP_W     = 2;
  localparam int IDX_W    = 4;
  localparam int ST_W     = 2;
  localparam int POS_W    = 5;
  localparam int CNT_W    = 5;
  localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int FILL_W   = $clog2(CAPACITY + 1);

  typedef enum logic [OP_W-1:0] {
    OP_APPEND  = 2'd0,
    OP_FIND    = 2'd1,
    OP_RM_VAL  = 2'd2,
    OP_RM_IDX  = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2,
    ST_RANGE    = 2'd3
  } status_t;

  typedef struct packed {
    logic              cmp_en;
    logic              exec;
    op_t               op;
    logic              rmi_ok;
    logic [DATA_W-1:0] data;
  } bcast_t;

endpackage

`default_nettype wire

// ===== rtl/cvl_cell.sv =====
// One storage cell of the compacting value list: holds an entry and its
// compare flag, loads the value on an append and takes its neighbour's entry on a removal.
// Depends on cvl_pkg.
`default_nettype none

module cvl_cell (
  input  logic                       clk,
  input  cvl_pkg::bcast_t            bc,
  input  logic                       live,
  input  logic                       at_count,
  input  logic                       ge_idx,
  input  logic                       hit_in,
  input  logic [cvl_pkg::DATA_W-1:0] next_entry,
  output logic                       hit_out,
  output logic                       first,
  output logic [cvl_pkg::DATA_W-1:0] entry
);

  logic [cvl_pkg::DATA_W-1:0] entry_r;
  logic                       match_r;

  assign hit_out = hit_in | match_r;
  assign first   = match_r & ~hit_in;
  assign entry   = entry_r;

  always_ff @(posedge clk) begin
    if (bc.cmp_en) begin
      match_r <= live && (entry_r == bc.data);
    end
    if (bc.exec) begin
      unique case (bc.op)
        cvl_pkg::OP_APPEND: if (at_count) entry_r <= bc.data;
        cvl_pkg::OP_FIND:   ;
        cvl_pkg::OP_RM_VAL: if (hit_out) entry_r <= next_entry;
        cvl_pkg::OP_RM_IDX: if (bc.rmi_ok && ge_idx) entry_r <= next_entry;
        default:            ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/compacting_value_list.sv =====
// Compacting value list, top level: request handling, fill count, row of
// cvl_cell storage cells and the result register. Depends on cvl_pkg, cvl_cell.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one operation per request:
//   append, find, remove by value, remove at index. Result channel
//   (out_valid/out_stall) returns exactly one result per request: status,
//   position (-1 when none) and the count after the operation.
//   In the accepting cycle every cell compares its entry with the value.
//   Then, in the execute state and once the output register is free, the
//   first-match hit ripples along the row, the cells shift or load, and the
//   result is written to the output register. in_stall is high in the
//   execute state, so no new request is accepted until the current one has
//   executed. If the receiver stalls, the result waits in the output
//   register; one more request may be accepted and compared, and it
//   completes once the register is free.
//   Reset empties the list (count zero) and clears out_valid; stored
//   entries are not cleared; those at or above the count never take part in a match.
`default_nettype none

module compacting_value_list (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [cvl_pkg::OP_W-1:0]    in_operation,
  input  logic signed [cvl_pkg::DATA_W-1:0] in_value,
  input  logic [cvl_pkg::IDX_W-1:0]   in_index,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [cvl_pkg::ST_W-1:0]    out_status,
  output logic signed [cvl_pkg::POS_W-1:0] out_position,
  output logic [cvl_pkg::CNT_W-1:0]   out_count
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t                       state_r, state_nxt;
  logic [cvl_pkg::FILL_W-1:0]   count_r, count_nxt;
  cvl_pkg::op_t                 op_r;
  logic [cvl_pkg::DATA_W-1:0]   value_r;
  logic [cvl_pkg::IDX_W-1:0]    index_r;

  logic                         out_valid_r;
  cvl_pkg::status_t             out_status_r, status_nxt;
  logic [cvl_pkg::POS_W-1:0]    out_position_r, position_nxt;
  logic [cvl_pkg::CNT_W-1:0]    out_count_r;

  logic                         accept;
  logic                         adv;
  logic                         rmi_ok;
  logic                         found;
  logic [cvl_pkg::SLOT_W-1:0]   hit_pos;
  cvl_pkg::bcast_t              bc;

  logic [cvl_pkg::CAPACITY:0]   hit;
  logic [cvl_pkg::CAPACITY-1:0] first;
  logic [cvl_pkg::DATA_W-1:0]   entry [cvl_pkg::CAPACITY];

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign adv      = (state_r == S_EXEC) && (!out_valid_r || !out_stall);
  assign rmi_ok   = (cvl_pkg::FILL_W'(index_r) < count_r);
  assign found    = hit[cvl_pkg::CAPACITY];

  always_comb begin
    bc.cmp_en = accept;
    bc.exec   = adv;
    bc.op     = op_r;
    bc.rmi_ok = rmi_ok;
    bc.data   = accept ? in_value : value_r;
  end

  assign hit[0] = 1'b0;

  for (genvar i = 0; i < cvl_pkg::CAPACITY; i++) begin : g_cell
    logic [cvl_pkg::DATA_W-1:0] nbr;
    if (i == cvl_pkg::CAPACITY - 1) begin : g_last
      assign nbr = entry[i];
    end else begin : g_mid
      assign nbr = entry[i+1];
    end
    cvl_cell u_cell (
      .clk        (clk),
      .bc         (bc),
      .live       (cvl_pkg::FILL_W'(i) < count_r),
      .at_count   (cvl_pkg::FILL_W'(i) == count_r),
      .ge_idx     (cvl_pkg::FILL_W'(i) >= cvl_pkg::FILL_W'(index_r)),
      .hit_in     (hit[i]),
      .next_entry (nbr),
      .hit_out    (hit[i+1]),
      .first      (first[i]),
      .entry      (entry[i])
    );
  end

  always_comb begin
    hit_pos = '0;
    for (int i = 0; i < cvl_pkg::CAPACITY; i++) begin
      if (first[i]) hit_pos = hit_pos | cvl_pkg::SLOT_W'(i);
    end
  end

  always_comb begin
    status_nxt   = cvl_pkg::ST_OK;
    position_nxt = '1;
    count_nxt    = count_r;
    unique case (op_r)
      cvl_pkg::OP_APPEND: begin
        if (count_r == cvl_pkg::FILL_W'(cvl_pkg::CAPACITY)) begin
          status_nxt = cvl_pkg::ST_FULL;
        end else begin
          position_nxt = cvl_pkg::POS_W'(count_r);
          count_nxt    = count_r + 1'b1;
        end
      end
      cvl_pkg::OP_FIND: begin
        if (found) position_nxt = cvl_pkg::POS_W'(hit_pos);
        else       status_nxt   = cvl_pkg::ST_NOTFOUND;
      end
      cvl_pkg::OP_RM_VAL: begin
        if (found) begin
          position_nxt = cvl_pkg::POS_W'(hit_pos);
          count_nxt    = count_r - 1'b1;
        end else begin
          status_nxt = cvl_pkg::ST_NOTFOUND;
        end
      end
      cvl_pkg::OP_RM_IDX: begin
        if (rmi_ok) begin
          position_nxt = cvl_pkg::POS_W'(index_r);
          count_nxt    = count_r - 1'b1;
        end else begin
          status_nxt = cvl_pkg::ST_RANGE;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_EXEC;
      S_EXEC:  if (adv)    state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (adv) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= cvl_pkg::op_t'(in_operation);
      value_r <= in_value;
      index_r <= in_index;
    end
    if (adv) begin
      out_status_r   <= status_nxt;
      out_position_r <= position_nxt;
      out_count_r    <= cvl_pkg::CNT_W'(count_nxt);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_position = out_position_r;
  assign out_count    = out_count_r;

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cvl_pkg::FILL_W'(cvl_pkg::CAPACITY))
    else $error("fill count above capacity");

  a_first_single: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXEC |-> $onehot0(first))
    else $error("more than one first match");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_EXEC)
    else $error("accepted request not executed");

  a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r && count_r == $past(count_nxt))
    else $error("result not presented after execution");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == cvl_pkg::ST_FULL
      |-> out_count_r == cvl_pkg::CNT_W'(cvl_pkg::CAPACITY))
    else $error("full reported below capacity");

endmodule

`default_nettype wire

// ===== dv/compacting_value_list_tb.sv =====
// Self-checking testbench for compacting_value_list: directed and random
// list operations over a valid/stall handshake, each checked against a local
// model of the list. Depends on cvl_pkg and the compacting_value_list RTL.
`default_nettype none

module compacting_value_list_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    cvl_pkg::op_t               op;
    logic [cvl_pkg::DATA_W-1:0] value;
    logic [cvl_pkg::IDX_W-1:0]  index;
  } list_req_t;

  typedef struct packed {
    cvl_pkg::status_t           status;
    logic [cvl_pkg::POS_W-1:0]  position;
    logic [cvl_pkg::CNT_W-1:0]  count;
  } list_result_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic [cvl_pkg::OP_W-1:0]          in_operation = '0;
  logic signed [cvl_pkg::DATA_W-1:0] in_value = '0;
  logic [cvl_pkg::IDX_W-1:0]         in_index = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic [cvl_pkg::ST_W-1:0]          out_status;
  logic signed [cvl_pkg::POS_W-1:0]  out_position;
  logic [cvl_pkg::CNT_W-1:0]         out_count;

  compacting_value_list uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_value     (in_value),
    .in_index     (in_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_position (out_position),
    .out_count    (out_count)
  );

  list_req_t                  pending_reqs[$];
  list_result_t               awaited_results[$];
  logic [cvl_pkg::DATA_W-1:0] list_mem [cvl_pkg::CAPACITY];
  int                         list_len = 0;
  int                         total_items = 0;
  int                         accepted = 0;
  int                         errors = 0;

  // driver state
  int drv_gap = 0;
  int drv_rate = 0;
  int drv_cyc = 0;

  // receiver state
  int rx_left = 0;
  int rx_hold = 0;
  int rx_rate = 0;
  int rx_cyc = 0;
  int rx_taken = 0;
  bit rx_pressed = 1'b0;
  logic next_stall;

  list_result_t want;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic void drop_entry(int pos);
    for (int i = pos; i < list_len - 1; i++) list_mem[i] = list_mem[i + 1];
    list_len--;
  endfunction

  function automatic list_result_t apply_op(list_req_t r);
    list_result_t res;
    int hit;
    res.status   = cvl_pkg::ST_OK;
    res.position = '1;
    hit = -1;
    case (r.op)
      cvl_pkg::OP_APPEND: begin
        if (list_len >= cvl_pkg::CAPACITY) begin
          res.status = cvl_pkg::ST_FULL;
        end else begin
          list_mem[list_len] = r.value;
          res.position = cvl_pkg::POS_W'(list_len);
          list_len++;
        end
      end
      cvl_pkg::OP_FIND, cvl_pkg::OP_RM_VAL: begin
        for (int i = 0; i < list_len; i++)
          if (hit < 0 && list_mem[i] == r.value) hit = i;
        if (hit < 0) begin
          res.status = cvl_pkg::ST_NOTFOUND;
        end else begin
          res.position = cvl_pkg::POS_W'(hit);
          if (r.op == cvl_pkg::OP_RM_VAL) drop_entry(hit);
        end
      end
      default: begin
        if (int'(r.index) < list_len) begin
          res.position = cvl_pkg::POS_W'(r.index);
          drop_entry(int'(r.index));
        end else begin
          res.status = cvl_pkg::ST_RANGE;
        end
      end
    endcase
    res.count = cvl_pkg::CNT_W'(list_len);
    return res;
  endfunction

  function automatic void push_req(cvl_pkg::op_t op, logic [cvl_pkg::DATA_W-1:0] v,
                                   logic [cvl_pkg::IDX_W-1:0] idx);
    list_req_t r;
    r.op    = op;
    r.value = v;
    r.index = idx;
    pending_reqs.push_back(r);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      drv_cyc++;
      if (drv_cyc % 50 == 0) drv_rate = $urandom_range(0, 3);
      if (in_valid && !in_stall) begin
        awaited_results.push_back(apply_op(pending_reqs.pop_front()));
        accepted++;
      end
      if (!(in_valid && in_stall)) begin
        if (drv_gap > 0) begin
          drv_gap--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() == 0) begin
          in_valid <= 1'b0;
        end else if (accepted < total_items - 100 && $urandom_range(0, 7) < drv_rate) begin
          drv_gap = $urandom_range(0, 4);
          in_valid <= 1'b0;
        end else begin
          in_valid     <= 1'b1;
          in_operation <= pending_reqs[0].op;
          in_value     <= pending_reqs[0].value;
          in_index     <= pending_reqs[0].index;
        end
      end
    end
  end

  // receiver stall, with one long hold-off to back the block up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      rx_cyc++;
      if (rx_cyc % 64 == 0) rx_rate = $urandom_range(0, 3);
      if (out_valid && !out_stall) rx_taken++;
      if (!rx_pressed && rx_taken >= 200) begin
        rx_pressed = 1'b1;
        rx_hold = 80;
      end
      if (rx_hold > 0) begin
        rx_hold--;
        next_stall = 1'b1;
      end else if (rx_left > 0) begin
        rx_left--;
        next_stall = 1'b1;
      end else if (rx_taken < total_items - 100 && $urandom_range(0, 7) < rx_rate) begin
        rx_left = $urandom_range(0, 4);
        next_stall = 1'b1;
      end else begin
        next_stall = 1'b0;
      end
      out_stall <= next_stall;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result: status %0d position %0d count %0d",
                 $time, out_status, out_position, out_count);
        errors++;
      end else begin
        want = awaited_results.pop_front();
        if (out_status !== want.status) begin
          $display("%0t: status mismatch: expected %0d actual %0d",
                   $time, want.status, out_status);
          errors++;
        end
        if (out_position !== want.position) begin
          $display("%0t: position mismatch: expected %0d actual %0d",
                   $time, $signed(want.position), out_position);
          errors++;
        end
        if (out_count !== want.count) begin
          $display("%0t: count mismatch: expected %0d actual %0d",
                   $time, want.count, out_count);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [cvl_pkg::DATA_W-1:0] pool [8];
    logic [cvl_pkg::DATA_W-1:0] v;
    logic [cvl_pkg::IDX_W-1:0]  idx;
    cvl_pkg::op_t op;
    int bias;
    int pick;
    pool[0] = 32'h8000_0000;
    pool[1] = 32'h7fff_ffff;
    pool[2] = 32'h0000_0000;
    pool[3] = 32'hffff_ffff;
    pool[4] = 32'h0000_0001;
    pool[5] = $urandom;
    pool[6] = $urandom;
    pool[7] = $urandom;

    // empty list
    push_req(cvl_pkg::OP_FIND,   32'h0000_0000, 4'd0);
    push_req(cvl_pkg::OP_RM_VAL, 32'hffff_ffff, 4'd15);
    push_req(cvl_pkg::OP_RM_IDX, 32'h0000_0000, 4'd0);
    // fill to capacity, with duplicates
    push_req(cvl_pkg::OP_APPEND, 32'h8000_0000, 4'd15);
    push_req(cvl_pkg::OP_APPEND, 32'h7fff_ffff, 4'd0);
    push_req(cvl_pkg::OP_APPEND, 32'hffff_ffff, 4'd0);
    push_req(cvl_pkg::OP_APPEND, 32'h0000_0000, 4'd0);
    push_req(cvl_pkg::OP_APPEND, 32'hffff_ffff, 4'd0);
    for (int i = 0; i < 11; i++)
      push_req(cvl_pkg::OP_APPEND, 32'(i * 32'h1111_1111), 4'(i));
    push_req(cvl_pkg::OP_APPEND, 32'h1234_5678, 4'd15);
    push_req(cvl_pkg::OP_FIND,   32'h7fff_ffff, 4'd0);
    push_req(cvl_pkg::OP_FIND,   32'h7fff_fffe, 4'd0);
    push_req(cvl_pkg::OP_RM_IDX, 32'h0000_0000, 4'd15);
    push_req(cvl_pkg::OP_RM_VAL, 32'hffff_ffff, 4'd0);
    push_req(cvl_pkg::OP_RM_IDX, 32'h0000_0000, 4'd15);

    bias = 1;
    for (int n = 0; n < 1000; n++) begin
      if (n % 40 == 0) bias = $urandom_range(0, 2);
      pick = $urandom_range(0, 99);
      if (pick < ((bias == 0) ? 60 : (bias == 1) ? 30 : 12)) op = cvl_pkg::OP_APPEND;
      else op = cvl_pkg::op_t'($urandom_range(1, 3));
      pick = $urandom_range(0, 9);
      if (pick < 6) v = pool[$urandom_range(0, 7)];
      else if (pick == 6) v = pool[$urandom_range(0, 7)] ^ (32'h1 << $urandom_range(0, 31));
      else v = $urandom;
      if ($urandom_range(0, 9) < 7) idx = 4'($urandom_range(0, 7));
      else idx = 4'($urandom_range(0, 15));
      push_req(op, v, idx);
    end
    total_items = pending_reqs.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    while (accepted < total_items || awaited_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0 && awaited_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/cvl_pkg.sv
rtl/cvl_cell.sv
rtl/compacting_value_list.sv
dv/compacting_value_list_tb.sv
